/* rtl/eeg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// eeg_pkg
// Shared types and constants for the extended Euclidean GCD core.
// -----------------------------------------------------------------------------
package eeg_pkg;

   // Output field widths, fixed by the interface
   localparam int unsigned DIVISOR_W = 31;
   localparam int unsigned COEFF_W   = 32;

   // Controller -> datapath commands
   typedef struct packed {
      logic load;       // capture operands, seed coefficients
      logic div_init;   // start a division of prev by cur
      logic div_step;   // one restoring-division bit
      logic mul;        // quotient times current coefficients
      logic update;     // advance remainder sequence
   } eeg_cmd_type;

   // Datapath -> controller status
   typedef struct packed {
      logic cur_zero;   // remainder sequence finished
      logic div_last;   // last quotient bit this cycle
   } eeg_status_type;

endpackage : eeg_pkg
`default_nettype wire

/* rtl/eeg_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// eeg_datapath
// Remainder sequence registers, bit-serial restoring divider, coefficient
// multiply and update.
// -----------------------------------------------------------------------------
module eeg_datapath import eeg_pkg::*; #(
   parameter int unsigned OPERAND_BITS = 31
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire eeg_cmd_type             cmd,
   output eeg_status_type               status,
   input  wire logic [OPERAND_BITS-1:0] operand_a,
   input  wire logic [OPERAND_BITS-1:0] operand_b,
   output logic [DIVISOR_W-1:0]         divisor,
   output logic [COEFF_W-1:0]           coeff_x,
   output logic [COEFF_W-1:0]           coeff_y
);

   localparam int unsigned W     = OPERAND_BITS;
   localparam int unsigned CNT_W = $clog2(W);

   logic [W-1:0]       cur_ff, cur_in;
   logic [W-1:0]       prev_ff, prev_in;
   logic [W-1:0]       rem_ff, rem_in;
   logic [W-1:0]       quo_ff, quo_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [COEFF_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [COEFF_W-1:0] px_ff, px_in, py_ff, py_in;
   logic [COEFF_W-1:0] prod_x_ff, prod_x_in, prod_y_ff, prod_y_in;

   logic [W:0]           shifted;
   logic [W:0]           cur_ext;
   logic                 ge;
   logic [COEFF_W-1:0]   q_lo;
   logic [COEFF_W-1:0]   mul_x, mul_y;

   // restoring division: one quotient bit per cycle, MSB first
   assign shifted = {rem_ff, quo_ff[W-1]};
   assign cur_ext = {1'b0, cur_ff};
   assign ge      = (shifted >= cur_ext);

   // only the low coefficient bits survive, so the quotient is resized to COEFF_W to match
   assign q_lo  = COEFF_W'(quo_ff);
   assign mul_x = q_lo * cx_ff;
   assign mul_y = q_lo * cy_ff;

   always_comb begin
      cur_in    = cur_ff;
      prev_in   = prev_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      prod_x_in = prod_x_ff;
      prod_y_in = prod_y_ff;
      if (cmd.load) begin
         cur_in  = operand_a;
         prev_in = operand_b;
         cx_in   = COEFF_W'(1);
         cy_in   = '0;
         px_in   = '0;
         py_in   = COEFF_W'(1);
      end
      if (cmd.div_init) begin
         rem_in = '0;
         quo_in = prev_ff;
         cnt_in = '0;
      end
      if (cmd.div_step) begin
         rem_in = ge ? W'(shifted - cur_ext) : W'(shifted);
         quo_in = {quo_ff[W-2:0], ge};
         cnt_in = cnt_ff + CNT_W'(1);
      end
      if (cmd.mul) begin
         prod_x_in = mul_x;
         prod_y_in = mul_y;
      end
      if (cmd.update) begin
         px_in   = cx_ff;
         py_in   = cy_ff;
         cx_in   = px_ff - prod_x_ff;
         cy_in   = py_ff - prod_y_ff;
         prev_in = cur_ff;
         cur_in  = rem_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      cur_ff    <= cur_in;
      prev_ff   <= prev_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      px_ff     <= px_in;
      py_ff     <= py_in;
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
   end

   assign status.cur_zero = (cur_ff == '0);
   assign status.div_last = (cnt_ff == CNT_W'(W - 1));

   assign divisor = DIVISOR_W'(prev_ff);
   assign coeff_x = px_ff;
   assign coeff_y = py_ff;

endmodule : eeg_datapath
`default_nettype wire

/* rtl/eeg_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// eeg_ctrl
// Sequencer: zero check, division, multiply and update phases of each quotient step.
// -----------------------------------------------------------------------------
module eeg_ctrl import eeg_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire eeg_status_type status,
   output eeg_cmd_type         cmd,
   output logic                busy,
   output logic                done
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_MULT,
      ST_UPDATE
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      done_ff;
   logic      accept;

   assign accept = start && !busy_ff;

   always_comb begin
      cmd          = '0;
      cmd.load     = accept;
      cmd.div_init = (state_ff == ST_CHECK) && !status.cur_zero;
      cmd.div_step = (state_ff == ST_DIVIDE);
      cmd.mul      = (state_ff == ST_MULT);
      cmd.update   = (state_ff == ST_UPDATE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_CHECK;
                  busy_ff  <= 1'b1;
               end
            end
            ST_CHECK: begin
               if (status.cur_zero) begin
                  state_ff <= ST_IDLE;
                  busy_ff  <= 1'b0;
                  done_ff  <= 1'b1;
               end else begin
                  state_ff <= ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               if (status.div_last) begin
                  state_ff <= ST_MULT;
               end
            end
            ST_MULT: begin
               state_ff <= ST_UPDATE;
            end
            ST_UPDATE: begin
               state_ff <= ST_CHECK;
            end
            default: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;

endmodule : eeg_ctrl
`default_nettype wire

/* rtl/extended_euclid_gcd_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// extended_euclid_gcd_core
// GCD of two unsigned operands with Bezout coefficients x, y: a*x + b*y = gcd.
//
// Channel   Ports                                      Handshake
// request   req_operand_a, req_operand_b               start && !busy
// response  rsp_divisor, rsp_coeff_x, rsp_coeff_y      rsp_valid, one cycle
//
// Each quotient step runs a zero check, a bit-serial restoring divider (one
// bit per cycle), a multiply and an update. One item is in flight at a
// time, busy is high meanwhile. Reset is synchronous and returns the core
// to idle. Results are not held back: rsp_valid lasts one cycle and fields
// hold until the next accept.
// -----------------------------------------------------------------------------
module extended_euclid_gcd_core import eeg_pkg::*; #(
   parameter int unsigned OPERAND_BITS = 31
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic [OPERAND_BITS-1:0] req_operand_a,
   input  wire logic [OPERAND_BITS-1:0] req_operand_b,
   output logic                         rsp_valid,
   output logic [DIVISOR_W-1:0]         rsp_divisor,
   output logic signed [COEFF_W-1:0]    rsp_coeff_x,
   output logic signed [COEFF_W-1:0]    rsp_coeff_y
);

   eeg_cmd_type        cmd;
   eeg_status_type     status;
   logic [COEFF_W-1:0] coeff_x;
   logic [COEFF_W-1:0] coeff_y;

   eeg_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy),
      .done   (rsp_valid)
   );

   eeg_datapath #(
      .OPERAND_BITS (OPERAND_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .operand_a (req_operand_a),
      .operand_b (req_operand_b),
      .divisor   (rsp_divisor),
      .coeff_x   (coeff_x),
      .coeff_y   (coeff_y)
   );

   assign rsp_coeff_x = $signed(coeff_x);
   assign rsp_coeff_y = $signed(coeff_y);

endmodule : extended_euclid_gcd_core
`default_nettype wire

/* rtl/eeg_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// eeg_checker
// Port-level checks on the GCD core's command handshake and result strobe.
// -----------------------------------------------------------------------------
module eeg_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid
);

   // an accepted item makes the core busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accept");

   // the result strobe is a single pulse
   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("rsp_valid held longer than one cycle");

   // a result only follows work on an item
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) && !busy)
      else $error("rsp_valid without a preceding busy item");

   // finishing an item always produces its result
   a_done_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_valid)
      else $error("busy dropped without a result");

endmodule : eeg_checker

bind extended_euclid_gcd_core eeg_checker u_eeg_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb
// Self-checking bench for extended_euclid_gcd_core. A queue of operand pairs
// (directed corner cases, then random pairs of several shapes) feeds a clocked
// driver; a clocked monitor checks gcd and both Bezout coefficients of every
// result against an iterative extended Euclid predictor, in order.
// -----------------------------------------------------------------------------
module tb;
   import eeg_pkg::*;

   localparam int unsigned OPW       = 31;
   localparam logic [OPW-1:0] OP_MAX = {OPW{1'b1}};
   localparam int unsigned MAX_STEPS = 46;                       // Fibonacci worst case
   localparam int unsigned LAT_MAX   = 2 + MAX_STEPS * (OPW + 3);
   localparam int unsigned WDOG_MAX  = 8 * LAT_MAX + 2000;
   localparam int unsigned N_RANDOM  = 268;

   typedef struct {
      logic [OPW-1:0] a;
      logic [OPW-1:0] b;
      int unsigned    idle_pct;   // chance in 100 that the sender holds off a cycle
      bit             drain;      // hold until every outstanding result is back
   } operand_item_type;

   typedef struct {
      logic [OPW-1:0]       a;
      logic [OPW-1:0]       b;
      logic [DIVISOR_W-1:0] gcd;
      logic [COEFF_W-1:0]   x;
      logic [COEFF_W-1:0]   y;
   } bezout_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic [OPW-1:0] req_operand_a = '0;
   logic [OPW-1:0] req_operand_b = '0;
   logic busy;
   logic rsp_valid;
   logic [DIVISOR_W-1:0]      rsp_divisor;
   logic signed [COEFF_W-1:0] rsp_coeff_x;
   logic signed [COEFF_W-1:0] rsp_coeff_y;

   operand_item_type operand_q[$];
   bezout_type       bezout_q[$];
   bezout_type       in_flight;
   int unsigned   n_sent     = 0;
   int unsigned   n_returned = 0;
   int unsigned   n_errors   = 0;
   int unsigned   quiet_cycles = 0;

   extended_euclid_gcd_core #(.OPERAND_BITS(OPW)) u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .rsp_valid     (rsp_valid),
      .rsp_divisor   (rsp_divisor),
      .rsp_coeff_x   (rsp_coeff_x),
      .rsp_coeff_y   (rsp_coeff_y)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Remainder sequence with coefficients carried along, wrapping mod 2^64
   function automatic bezout_type bezout_of(input logic [OPW-1:0] a,
                                            input logic [OPW-1:0] b);
      logic [63:0] r_cur, r_prv, x_cur, y_cur, x_prv, y_prv, quo, r_nxt, x_nxt, y_nxt;
      bezout_type res;
      r_cur = 64'(a);
      r_prv = 64'(b);
      x_cur = 64'd1;
      y_cur = 64'd0;
      x_prv = 64'd0;
      y_prv = 64'd1;
      while (r_cur != 64'd0) begin
         quo   = r_prv / r_cur;
         r_nxt = r_prv - quo * r_cur;
         x_nxt = x_prv - quo * x_cur;
         y_nxt = y_prv - quo * y_cur;
         x_prv = x_cur;
         y_prv = y_cur;
         x_cur = x_nxt;
         y_cur = y_nxt;
         r_prv = r_cur;
         r_cur = r_nxt;
      end
      res.a   = a;
      res.b   = b;
      res.gcd = r_prv[DIVISOR_W-1:0];
      res.x   = x_prv[COEFF_W-1:0];
      res.y   = y_prv[COEFF_W-1:0];
      return res;
   endfunction

   function automatic logic [OPW-1:0] fib(input int unsigned k);
      logic [63:0] f0, f1, fn;
      f0 = 64'd0;
      f1 = 64'd1;
      for (int unsigned i = 0; i < k; i++) begin
         fn = f0 + f1;
         f0 = f1;
         f1 = fn;
      end
      return f0[OPW-1:0];
   endfunction

   function automatic logic [OPW-1:0] rand_op();
      return OPW'($urandom);
   endfunction

   task automatic add_pair(input logic [OPW-1:0] a, input logic [OPW-1:0] b,
                           input int unsigned idle_pct, input bit drain);
      operand_item_type it;
      it.a        = a;
      it.b        = b;
      it.idle_pct = idle_pct;
      it.drain    = drain;
      operand_q.push_back(it);
   endtask

   // Random pair of one of several shapes
   task automatic add_random_pair(input int unsigned idle_pct, input bit drain);
      logic [OPW-1:0] a, b, msk;
      logic [63:0]    g, m, n;
      int unsigned    k;
      case ($urandom_range(9))
         0, 1, 2: begin
            a = rand_op();
            b = rand_op();
         end
         3: begin
            msk = OP_MAX >> $urandom_range(OPW - 1);
            a   = rand_op() & msk;
            msk = OP_MAX >> $urandom_range(OPW - 1);
            b   = rand_op() & msk;
         end
         4: begin
            // large shared factor
            g = 64'($urandom_range(65535, 1));
            m = 64'($urandom) % (64'(OP_MAX) / g + 1);
            n = 64'($urandom) % (64'(OP_MAX) / g + 1);
            a = OPW'(g * m);
            b = OPW'(g * n);
         end
         5: begin
            // consecutive Fibonacci numbers give the longest sequences
            k = $urandom_range(MAX_STEPS - 1, 1);
            if ($urandom_range(1)) begin
               a = fib(k);
               b = fib(k + 1);
            end else begin
               a = fib(k + 1);
               b = fib(k);
            end
         end
         6: begin
            a = $urandom_range(1) ? '0 : rand_op();
            b = (a == '0) ? rand_op() : '0;
         end
         7: begin
            a = OPW'($urandom_range(15));
            b = OPW'($urandom_range(15));
         end
         8: begin
            a = OP_MAX - OPW'($urandom_range(255));
            b = $urandom_range(1) ? OP_MAX - OPW'($urandom_range(255)) : rand_op();
         end
         default: begin
            a = rand_op() >> $urandom_range(OPW - 1);
            b = $urandom_range(1) ? a : OPW'(64'(a) * $urandom_range(64, 1));
         end
      endcase
      add_pair(a, b, idle_pct, drain);
   endtask

   // Driver: a pair is taken at an edge with start high and busy low
   always @(posedge clock) begin
      operand_item_type nxt;
      bit            send;
      bit            outstanding;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            bezout_q.push_back(in_flight);
            n_sent <= n_sent + 1;
         end
         if (!start || !busy) begin
            send = 1'b0;
            outstanding = (start && !busy) || (n_sent != n_returned);
            if (operand_q.size() != 0) begin
               nxt  = operand_q[0];
               send = ($urandom_range(99) >= nxt.idle_pct) && !(nxt.drain && outstanding);
            end
            if (send) begin
               void'(operand_q.pop_front());
               in_flight = bezout_of(nxt.a, nxt.b);
               req_operand_a <= nxt.a;
               req_operand_b <= nxt.b;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: rsp_valid lasts one cycle and cannot be held off
   always @(posedge clock) begin
      bezout_type exp_res;
      if (!reset && rsp_valid) begin
         n_returned <= n_returned + 1;
         if (bezout_q.size() == 0) begin
            n_errors = n_errors + 1;
            if (n_errors <= 10)
               $display("%0t: unexpected result gcd=%0d x=%0d y=%0d", $time,
                        rsp_divisor, rsp_coeff_x, rsp_coeff_y);
         end else begin
            exp_res = bezout_q.pop_front();
            if (rsp_divisor !== exp_res.gcd || rsp_coeff_x !== exp_res.x ||
                rsp_coeff_y !== exp_res.y) begin
               n_errors = n_errors + 1;
               if (n_errors <= 10)
                  $display({"%0t: a=%0d b=%0d expected gcd=%0d x=%0d y=%0d,",
                            " got gcd=%0d x=%0d y=%0d"},
                           $time, exp_res.a, exp_res.b, exp_res.gcd, $signed(exp_res.x),
                           $signed(exp_res.y), rsp_divisor, rsp_coeff_x, rsp_coeff_y);
            end
         end
      end
   end

   // Watchdog on cycles with neither an accepted item nor a result
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WDOG_MAX) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned idle_pct;
      // Directed corners, no idling
      add_pair('0, '0, 0, 1'b0);
      add_pair('0, 31'd12345, 0, 1'b0);
      add_pair('0, OP_MAX, 0, 1'b0);
      add_pair(31'd987654, '0, 0, 1'b0);
      add_pair(OP_MAX, '0, 0, 1'b0);
      add_pair(OP_MAX, OP_MAX, 0, 1'b0);
      add_pair(OP_MAX, 31'd1, 0, 1'b0);
      add_pair(31'd1, OP_MAX, 0, 1'b0);
      add_pair(31'd1, 31'd1, 0, 1'b0);
      add_pair(OP_MAX, OP_MAX - 31'd1, 0, 1'b0);
      add_pair(OP_MAX - 31'd1, OP_MAX, 0, 1'b0);
      add_pair(fib(MAX_STEPS), fib(MAX_STEPS - 1), 0, 1'b0);
      add_pair(fib(MAX_STEPS - 1), fib(MAX_STEPS), 0, 1'b0);
      add_pair(31'h5555_5555, 31'h2AAA_AAAA, 0, 1'b0);
      add_pair(31'h4000_0000, 31'h0000_0400, 0, 1'b0);
      add_pair(31'd240, 31'd46, 0, 1'b0);
      add_pair(31'd46, 31'd240, 0, 1'b0);
      add_pair(31'd99, 31'd78, 0, 1'b0);
      add_pair(31'd2147483629, OP_MAX, 0, 1'b0);
      add_pair(31'd1000000, 31'd1000000, 0, 1'b0);
      add_pair(31'd7, 31'd700000007, 0, 1'b0);
      // Random pairs in three idling phases; each phase opens after a full drain
      for (int unsigned i = 0; i < N_RANDOM; i++) begin
         case (i * 3 / N_RANDOM)
            0:       idle_pct = 0;
            1:       idle_pct = 83;
            default: idle_pct = 20;
         endcase
         add_random_pair(idle_pct,
                         (i == 0) || (i * 3 / N_RANDOM != (i - 1) * 3 / N_RANDOM) ||
                         ($urandom_range(39) == 0));
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (operand_q.size() != 0 || start || n_sent != n_returned)
         @(negedge clock);
      repeat (LAT_MAX) @(negedge clock);
      if (bezout_q.size() != 0)
         n_errors = n_errors + bezout_q.size();

      if (n_errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/eeg_pkg.sv
rtl/eeg_datapath.sv
rtl/eeg_ctrl.sv
rtl/extended_euclid_gcd_core.sv
rtl/eeg_checker.sv
tb/tb.sv
